>>> hw/rtl/jdrc_pkg.sv
// ---------------------------------------------------------------------------
// jdrc_pkg: shared types and constants for the joystick conditioning block
// Holds register codes, reset values, the sequencer state type and the
// per-axis dead-zone function.
// ---------------------------------------------------------------------------
package jdrc_pkg;

  localparam int NumPorts = 2;
  localparam int AxisW    = 8;
  localparam int BtnW     = 16;
  localparam int OutW     = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDeadZone   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAxisOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxMag     = 2'd2;

  localparam logic [6:0] DeadZoneRst   = 7'd8;
  localparam logic [6:0] AxisOffsetRst = 7'd6;
  localparam logic [7:0] MaxMagRst     = 8'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_L,
    ST_CHECK,
    ST_MUL_N,
    ST_DIV,
    ST_SQRT,
    ST_POST,
    ST_FINISH
  } jdrc_state_e;

  // Conditioned axis as sign and magnitude (magnitude 0..128)
  typedef struct packed {
    logic       neg;
    logic [7:0] mag;
  } axis_t;

  // Dead zone and offset toward zero; the positive test wins at zero dead zone
  function automatic axis_t cond_axis(logic [7:0] raw, logic [6:0] dz, logic [6:0] off);
    logic signed [8:0] r9;
    logic signed [8:0] dz9;
    logic signed [8:0] off9;
    logic signed [8:0] v9;
    logic signed [8:0] abs9;
    axis_t             res;
    r9   = $signed({raw[7], raw});
    dz9  = $signed({2'b00, dz});
    off9 = $signed({2'b00, off});
    v9   = '0;
    if (r9 <= -dz9) begin
      v9 = r9 + off9;
    end
    if (r9 >= dz9) begin
      v9 = r9 - off9;
    end
    abs9     = v9[8] ? -v9 : v9;
    res.neg  = v9[8];
    res.mag  = abs9[7:0];
    return res;
  endfunction

endpackage

>>> hw/rtl/joystick_deadzone_radial_clamp.sv
// ---------------------------------------------------------------------------
// joystick_deadzone_radial_clamp: analog stick dead zone and radial clamp
// Conditions one controller poll per request and detects newly pressed
// buttons per port.
// ---------------------------------------------------------------------------
// Usage:
//   A poll request enters on in_valid_i while in_stall_o is low. in_stall_o
//   stays high while the sequencer works on a request, so one poll is in
//   flight at a time. The result leaves on out_valid_o / out_stall_i from an
//   output register, so the next poll may be taken while a result waits.
//   The multiplies and the divide and root steps share one 16x16 multiplier
//   and one 19-bit subtract/compare, under a small sequencer:
//     disconnected port : skips the arithmetic, straight to the output register
//     no clamp          : 3 multiplies, 16 square-root steps
//     clamped vector    : per axis, 32 restoring divide steps and 16
//                         square-root steps
//   Reset loads the default dead zone, offset and limit and clears the held
//   button state of every port; no clearing pass is needed.
//   While the receiver stalls, the result holds and the finished next result
//   waits in the sequencer until the output register frees.
//   Configuration writes are registered; write them only while idle.
// ---------------------------------------------------------------------------
module joystick_deadzone_radial_clamp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [jdrc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [jdrc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // poll request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           port_i,
  input  logic                           connected_i,
  input  logic signed [jdrc_pkg::AxisW-1:0] raw_x_i,
  input  logic signed [jdrc_pkg::AxisW-1:0] raw_y_i,
  input  logic [jdrc_pkg::BtnW-1:0]      buttons_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [jdrc_pkg::OutW-1:0] stick_x_o,
  output logic signed [jdrc_pkg::OutW-1:0] stick_y_o,
  output logic [jdrc_pkg::OutW-1:0]      magnitude_o,
  output logic [jdrc_pkg::BtnW-1:0]      buttons_pressed_o,
  output logic [jdrc_pkg::BtnW-1:0]      buttons_held_o
);

  import jdrc_pkg::*;

  // Control state
  jdrc_state_e                    state_q, state_d;
  logic [6:0]                     dz_q, off_q;
  logic [7:0]                     lim_q;
  logic [NumPorts-1:0][BtnW-1:0]  held_q, held_d;
  logic                           out_valid_q, out_valid_d;

  // Request payload
  logic             conn_q, conn_d;
  logic [BtnW-1:0]  btn_q, btn_d;
  logic [BtnW-1:0]  pressed_q, pressed_d;
  logic [7:0]       ax_q, ax_d, ay_q, ay_d;
  logic             sx_q, sx_d, sy_q, sy_d;

  // Working registers of the shared unit
  logic [14:0]      ax2_q, ax2_d, ay2_q, ay2_d;
  logic [15:0]      s_q, s_d;
  logic [15:0]      lim2_q, lim2_d;
  logic             clamp_q, clamp_d;
  logic             axis_q, axis_d;
  logic [31:0]      acc_q, acc_d;
  logic [16:0]      rem_q, rem_d;
  logic [15:0]      root_q, root_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [OutW-1:0]  res_x_q, res_x_d, res_y_q, res_y_d, mag_q, mag_d;

  // Output register
  logic [OutW-1:0]  out_x_q, out_x_d, out_y_q, out_y_d, out_mag_q, out_mag_d;
  logic [BtnW-1:0]  out_pr_q, out_pr_d, out_held_q, out_held_d;

  // Shared arithmetic
  logic [15:0]      mul_a, mul_b;
  logic [31:0]      prod;
  logic [18:0]      sub_a, sub_b;
  logic [19:0]      diff;
  logic             sub_ge;
  logic [16:0]      div_r2;
  logic [18:0]      sqrt_r2;

  logic             in_acc, out_load, out_take;
  logic [BtnW-1:0]  prev_btn;
  axis_t            cx, cy;
  logic [15:0]      root_signed;
  logic             root_neg;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_take = out_valid_q && !out_stall_i;
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  assign cx = cond_axis(raw_x_i, dz_q, off_q);
  assign cy = cond_axis(raw_y_i, dz_q, off_q);

  // Previous held set of the addressed port; zero beyond the port count
  always_comb begin
    prev_btn = '0;
    for (int i = 0; i < NumPorts; i++) begin
      if (32'(port_i) == i) begin
        prev_btn = held_q[i];
      end
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_X: begin
        mul_a = {8'd0, ax_q};
        mul_b = {8'd0, ax_q};
      end
      ST_MUL_Y: begin
        mul_a = {8'd0, ay_q};
        mul_b = {8'd0, ay_q};
      end
      ST_MUL_L: begin
        mul_a = {8'd0, lim_q};
        mul_b = {8'd0, lim_q};
      end
      ST_MUL_N: begin
        mul_a = {1'b0, (axis_q ? ay2_q : ax2_q)};
        mul_b = lim2_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 32'(mul_a) * 32'(mul_b);

  // Subtract/compare operand select: divide step or root step
  assign div_r2  = {rem_q[15:0], acc_q[31]};
  assign sqrt_r2 = {rem_q, acc_q[31:30]};

  always_comb begin
    if (state_q == ST_DIV) begin
      sub_a = {2'b00, div_r2};
      sub_b = {3'b000, s_q};
    end else begin
      sub_a = sqrt_r2;
      sub_b = {1'b0, root_q, 2'b01};
    end
  end

  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !diff[19];

  assign root_neg    = axis_q ? sy_q : sx_q;
  assign root_signed = root_neg ? (16'd0 - root_q) : root_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = connected_i ? ST_MUL_X : ST_FINISH;
        end
      end
      ST_MUL_X: state_d = ST_MUL_Y;
      ST_MUL_Y: state_d = ST_MUL_L;
      ST_MUL_L: state_d = ST_CHECK;
      ST_CHECK: state_d = (s_q > lim2_q) ? ST_MUL_N : ST_SQRT;
      ST_MUL_N: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == 5'd31) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_q == 5'd15) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        if (clamp_q && !axis_q) begin
          state_d = ST_MUL_N;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    held_d      = held_q;
    out_valid_d = out_valid_q;
    conn_d      = conn_q;
    btn_d       = btn_q;
    pressed_d   = pressed_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    ax2_d       = ax2_q;
    ay2_d       = ay2_q;
    s_d         = s_q;
    lim2_d      = lim2_q;
    clamp_d     = clamp_q;
    axis_d      = axis_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    root_d      = root_q;
    cnt_d       = cnt_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    mag_d       = mag_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_mag_d   = out_mag_q;
    out_pr_d    = out_pr_q;
    out_held_d  = out_held_q;

    if (out_take) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          conn_d    = connected_i;
          btn_d     = buttons_i;
          pressed_d = buttons_i & ~prev_btn;
          ax_d      = cx.mag;
          sx_d      = cx.neg;
          ay_d      = cy.mag;
          sy_d      = cy.neg;
          // Record this poll as the port's held set; a disconnect clears it
          for (int i = 0; i < NumPorts; i++) begin
            if (32'(port_i) == i) begin
              held_d[i] = connected_i ? buttons_i : '0;
            end
          end
        end
      end
      ST_MUL_X: ax2_d = prod[14:0];
      ST_MUL_Y: ay2_d = prod[14:0];
      ST_MUL_L: begin
        lim2_d = prod[15:0];
        s_d    = {1'b0, ax2_q} + {1'b0, ay2_q};
      end
      ST_CHECK: begin
        clamp_d = s_q > lim2_q;
        axis_d  = 1'b0;
        // Unclamped: root of s in Q8.8 takes the radicand s shifted by 16
        acc_d   = {s_q, 16'h0000};
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
      end
      ST_MUL_N: begin
        // Dividend is a^2*lim^2 shifted by 16; its top part is below s
        rem_d = {2'b00, prod[30:16]};
        acc_d = {prod[15:0], 16'h0000};
        cnt_d = '0;
      end
      ST_DIV: begin
        if (sub_ge) begin
          rem_d = diff[16:0];
        end else begin
          rem_d = div_r2;
        end
        acc_d = {acc_q[30:0], sub_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          // Quotient is in place; start the root on it
          rem_d  = '0;
          root_d = '0;
          cnt_d  = '0;
        end
      end
      ST_SQRT: begin
        if (sub_ge) begin
          rem_d  = diff[16:0];
          root_d = {root_q[14:0], 1'b1};
        end else begin
          rem_d  = sqrt_r2[16:0];
          root_d = {root_q[14:0], 1'b0};
        end
        acc_d = {acc_q[29:0], 2'b00};
        cnt_d = cnt_q + 5'd1;
      end
      ST_POST: begin
        if (clamp_q) begin
          if (axis_q) begin
            res_y_d = root_signed;
          end else begin
            res_x_d = root_signed;
          end
          axis_d = 1'b1;
          mag_d  = {lim_q, 8'h00};
        end else begin
          res_x_d = sx_q ? (16'd0 - {ax_q, 8'h00}) : {ax_q, 8'h00};
          res_y_d = sy_q ? (16'd0 - {ay_q, 8'h00}) : {ay_q, 8'h00};
          mag_d   = root_q;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_x_d     = conn_q ? res_x_q : '0;
          out_y_d     = conn_q ? res_y_q : '0;
          out_mag_d   = conn_q ? mag_q : '0;
          out_pr_d    = conn_q ? pressed_q : '0;
          out_held_d  = conn_q ? btn_q : '0;
        end
      end
      default: begin
        out_valid_d = out_valid_q;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dz_q        <= DeadZoneRst;
      off_q       <= AxisOffsetRst;
      lim_q       <= MaxMagRst;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegDeadZone:   dz_q  <= cfg_wdata_i[6:0];
          RegAxisOffset: off_q <= cfg_wdata_i[6:0];
          RegMaxMag:     lim_q <= cfg_wdata_i;
          default: begin
            lim_q <= lim_q;
          end
        endcase
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    conn_q     <= conn_d;
    btn_q      <= btn_d;
    pressed_q  <= pressed_d;
    ax_q       <= ax_d;
    ay_q       <= ay_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    ax2_q      <= ax2_d;
    ay2_q      <= ay2_d;
    s_q        <= s_d;
    lim2_q     <= lim2_d;
    clamp_q    <= clamp_d;
    axis_q     <= axis_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    cnt_q      <= cnt_d;
    res_x_q    <= res_x_d;
    res_y_q    <= res_y_d;
    mag_q      <= mag_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_mag_q  <= out_mag_d;
    out_pr_q   <= out_pr_d;
    out_held_q <= out_held_d;
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign stick_x_o         = out_x_q;
  assign stick_y_o         = out_y_q;
  assign magnitude_o       = out_mag_q;
  assign buttons_pressed_o = out_pr_q;
  assign buttons_held_o    = out_held_q;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: poll conditioning check for joystick_deadzone_radial_clamp
// Drives controller poll requests through the valid/stall channel, predicts
// each conditioned result (dead zone, radial clamp, button edges per port)
// in a model or from a fixed row, and compares every result field in arrival order.
// ---------------------------------------------------------------------------
module testbench;

  import jdrc_pkg::*;

  // One poll request as it enters the block
  typedef struct packed {
    logic              port;
    logic              connected;
    logic signed [7:0] raw_x;
    logic signed [7:0] raw_y;
    logic [15:0]       buttons;
  } poll_t;

  // One conditioned result as it leaves the block
  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [15:0]        magnitude;
    logic [15:0]        buttons_pressed;
    logic [15:0]        buttons_held;
  } poll_result_t;

  // Directed table rows: either a poll request or a register write
  typedef enum logic [0:0] {
    ROW_POLL,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   reg_idx;
    logic [CfgDataW-1:0]  reg_data;
    poll_t                poll;
    logic                 fixed;
    poll_result_t         want;
  } stim_row_t;

  localparam int RandomPhases   = 8;
  localparam int PollsPerPhase  = 160;
  localparam int HoldOffCycles  = 300;
  localparam int SettleCycles   = 150;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 port_i = 1'b0;
  logic                 connected_i = 1'b0;
  logic signed [7:0]    raw_x_i = '0;
  logic signed [7:0]    raw_y_i = '0;
  logic [15:0]          buttons_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [15:0]   stick_x_o;
  logic signed [15:0]   stick_y_o;
  logic [15:0]          magnitude_o;
  logic [15:0]          buttons_pressed_o;
  logic [15:0]          buttons_held_o;

  // Local copy of the block's registers and per-port button memory
  logic [6:0]   dead_zone_cfg;
  logic [6:0]   axis_offset_cfg;
  logic [7:0]   max_mag_cfg;
  logic [15:0]  held_by_port [NumPorts];

  poll_result_t results_due [$];
  stim_row_t    directed_rows [$];
  int           fail_count = 0;
  bit           quiet_run = 1'b0;   // no random idling on either side
  int           hold_asks = 0;      // bumped by the sender to ask for a hold-off
  int           hold_seen = 0;
  int           hold_left = 0;

  joystick_deadzone_radial_clamp uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .port_i            (port_i),
    .connected_i       (connected_i),
    .raw_x_i           (raw_x_i),
    .raw_y_i           (raw_y_i),
    .buttons_i         (buttons_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .stick_x_o         (stick_x_o),
    .stick_y_o         (stick_y_o),
    .magnitude_o       (magnitude_o),
    .buttons_pressed_o (buttons_pressed_o),
    .buttons_held_o    (buttons_held_o)
  );

  always #5 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // Integer square root, truncated, bit by bit
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v   = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Dead zone then offset toward zero; the positive test is applied last so
  // it wins when the dead zone is zero and the axis sits exactly at 0.
  function automatic int live_axis(logic signed [7:0] raw);
    int r;
    int dzv;
    int offv;
    int v;
    r    = raw;
    dzv  = dead_zone_cfg;
    offv = axis_offset_cfg;
    v    = 0;
    if (r <= -dzv) v = r + offv;
    if (r >= dzv) v = r - offv;
    return v;
  endfunction

  // Rescale one axis so the vector lands on the limit: |a|*lim/sqrt(s) in
  // Q8.8, truncated toward zero, sign of the axis kept.
  function automatic int clamp_axis(int a, longint unsigned lim, longint unsigned s);
    longint unsigned m;
    longint unsigned q;
    m = (a < 0) ? -a : a;
    q = root64((m * m * 65536 * lim * lim) / s);
    return (a < 0) ? -int'(q) : int'(q);
  endfunction

  // Work out the result of one accepted poll and advance the port's memory
  function automatic poll_result_t condition_poll(poll_t p);
    int               x;
    int               y;
    longint unsigned  s;
    longint unsigned  lim;
    poll_result_t     r;
    r = '0;
    // Absent controller: all zeros, forget what was held
    if (!p.connected) begin
      held_by_port[p.port] = '0;
      return r;
    end
    x   = live_axis(p.raw_x);
    y   = live_axis(p.raw_y);
    s   = x * x + y * y;
    lim = max_mag_cfg;
    // Clamp on the exact squared length, not on the truncated magnitude
    if (s > lim * lim) begin
      r.stick_x   = 16'(clamp_axis(x, lim, s));
      r.stick_y   = 16'(clamp_axis(y, lim, s));
      r.magnitude = 16'(lim * 256);
    end else begin
      r.stick_x   = 16'(x * 256);
      r.stick_y   = 16'(y * 256);
      r.magnitude = 16'(root64(s << 16));
    end
    r.buttons_pressed    = p.buttons & ~held_by_port[p.port];
    r.buttons_held       = p.buttons;
    held_by_port[p.port] = p.buttons;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers: every task starts and ends on a falling edge
  // -------------------------------------------------------------------------

  // Offer one poll request, hold it until accepted, queue its result
  task automatic send_poll(poll_t p, bit fixed, poll_result_t want);
    poll_result_t predicted;
    while (!quiet_run && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    port_i      <= p.port;
    connected_i <= p.connected;
    raw_x_i     <= p.raw_x;
    raw_y_i     <= p.raw_y;
    buttons_i   <= p.buttons;
    do @(posedge clk_i); while (in_stall_o);
    // Run the model even for typed rows so the port memory stays in step
    predicted = condition_poll(p);
    results_due.push_back(fixed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (results_due.size() != 0) @(negedge clk_i);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegDeadZone:   dead_zone_cfg   = data[6:0];
      RegAxisOffset: axis_offset_cfg = data[6:0];
      RegMaxMag:     max_mag_cfg     = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(int dz, int off, int lim);
    write_reg(RegDeadZone, CfgDataW'(dz));
    write_reg(RegAxisOffset, CfgDataW'(off));
    write_reg(RegMaxMag, CfgDataW'(lim));
  endtask

  // Table builders for the directed part
  function automatic poll_t make_poll(logic port, logic conn, int x, int y, logic [15:0] btn);
    poll_t p;
    p.port      = port;
    p.connected = conn;
    p.raw_x     = 8'(x);
    p.raw_y     = 8'(y);
    p.buttons   = btn;
    return p;
  endfunction

  task automatic add_poll(logic port, logic conn, int x, int y, logic [15:0] btn);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_POLL;
    row.poll = make_poll(port, conn, x, y, btn);
    directed_rows.push_back(row);
  endtask

  task automatic add_fixed(logic port, logic conn, int x, int y, logic [15:0] btn,
                           logic [15:0] sx, logic [15:0] sy, logic [15:0] mag,
                           logic [15:0] pressed, logic [15:0] held);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_POLL;
    row.poll  = make_poll(port, conn, x, y, btn);
    row.fixed = 1'b1;
    row.want  = {sx, sy, mag, pressed, held};
    directed_rows.push_back(row);
  endtask

  task automatic add_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    stim_row_t row;
    row          = '0;
    row.kind     = ROW_REG;
    row.reg_idx  = idx;
    row.reg_data = data;
    directed_rows.push_back(row);
  endtask

  // Raw axis value: uniform, around the dead-zone edge, at an extreme or 0 or +-1, or within +-20
  function automatic logic signed [7:0] pick_axis();
    int k;
    int v;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      v = $urandom_range(0, 255) - 128;
    end else if (k < 6) begin
      v = int'(dead_zone_cfg) + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1)) v = -v;
    end else if (k < 8) begin
      case ($urandom_range(0, 4))
        0: v = -128;
        1: v = 127;
        2: v = 0;
        3: v = 1;
        default: v = -1;
      endcase
    end else begin
      v = $urandom_range(0, 40) - 20;
    end
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return 8'(v);
  endfunction

  function automatic poll_t random_poll();
    poll_t p;
    int    k;
    p.port      = 1'($urandom_range(0, 1));
    p.connected = ($urandom_range(0, 99) < 88);
    p.raw_x     = pick_axis();
    p.raw_y     = pick_axis();
    k = $urandom_range(0, 9);
    // Half the time flip a few bits of what the port holds, so edges stay sparse
    if (k < 3)      p.buttons = 16'($urandom);
    else if (k < 8) p.buttons = held_by_port[p.port] ^ 16'($urandom & $urandom & $urandom);
    else if (k < 9) p.buttons = '0;
    else            p.buttons = '1;
    return p;
  endfunction

  // -------------------------------------------------------------------------
  // Result side: stall driver and checker
  // -------------------------------------------------------------------------

  // Stall at random, or hold off for a long stretch when the sender asks
  always @(negedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_run && ($urandom_range(0, 99) < 10);
    end
  end

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %h, got %h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    poll_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $error("result arrived with no poll request outstanding");
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("stick_x", want.stick_x, stick_x_o);
        check_field("stick_y", want.stick_y, stick_y_o);
        check_field("magnitude", want.magnitude, magnitude_o);
        check_field("buttons_pressed", want.buttons_pressed, buttons_pressed_o);
        check_field("buttons_held", want.buttons_held, buttons_held_o);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    dead_zone_cfg   = DeadZoneRst;
    axis_offset_cfg = AxisOffsetRst;
    max_mag_cfg     = MaxMagRst;
    for (int i = 0; i < NumPorts; i++) held_by_port[i] = '0;

    // Directed table, reset settings first (dead zone 8, offset 6, limit 64)
    add_fixed(0, 0, 127, -128, 16'hFFFF, 0, 0, 0, 0, 0);         // absent: all zero
    add_fixed(0, 1, 0, 0, 16'h0001, 0, 0, 0, 16'h0001, 16'h0001);
    add_fixed(0, 1, 127, 0, 16'h0003, 16'h4000, 0, 16'h4000, 16'h0002, 16'h0003);
    add_fixed(1, 1, -128, 0, 16'hFFFF, 16'hC000, 0, 16'h4000, 16'hFFFF, 16'hFFFF);
    add_fixed(1, 1, 7, -7, 16'h8000, 0, 0, 0, 0, 16'h8000);      // both inside dead zone
    add_poll(0, 1, 8, -8, 16'h0000);                              // right at the threshold
    add_fixed(0, 1, 0, 127, 16'h5555, 0, 16'h4000, 16'h4000, 16'h5555, 16'h5555);
    add_poll(0, 1, -128, 127, 16'hAAAA);
    add_fixed(0, 0, 5, 5, 16'h1234, 0, 0, 0, 0, 0);               // clears port 0 memory
    add_poll(0, 1, -9, 9, 16'hFFFF);
    // Zero dead zone: an axis at exactly 0 takes the positive rule
    add_reg(RegDeadZone, 0);
    add_poll(1, 1, 0, 0, 16'h0000);
    // Zero limit: every nonzero vector collapses
    add_reg(RegMaxMag, 0);
    add_fixed(0, 1, 50, -3, 16'h00F0, 0, 0, 0, 0, 16'h00F0);
    add_poll(0, 1, 0, 0, 16'h0F0F);
    // Top extremes of dead zone and offset, with the limit at 181
    add_reg(RegDeadZone, 127);
    add_reg(RegAxisOffset, 127);
    add_reg(RegMaxMag, 181);
    add_poll(0, 1, 127, -127, 16'hF0F0);
    add_poll(1, 1, -128, 126, 16'h7FFF);
    // No dead zone, no offset: corner vectors just above and below the limit
    add_reg(RegDeadZone, 0);
    add_reg(RegAxisOffset, 0);
    add_poll(0, 1, -128, -128, 16'h0000);
    add_poll(1, 1, 127, 127, 16'hFFFF);
    add_poll(1, 1, -128, 127, 16'h0000);

    // Hold reset, then release on a falling edge
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_poll(directed_rows[i].poll, directed_rows[i].fixed, directed_rows[i].want);
      end
    end

    // Random phases, each under its own register settings
    for (int ph = 0; ph < RandomPhases; ph++) begin
      drain_results();
      case (ph)
        0: program_regs(DeadZoneRst, AxisOffsetRst, MaxMagRst);
        1: program_regs(0, 0, 181);
        2: program_regs(127, 127, 1);
        5: program_regs($urandom_range(0, 30), $urandom_range(0, 127), 0);
        default: program_regs($urandom_range(0, 40), $urandom_range(0, 40),
                              $urandom_range(1, 181));
      endcase
      quiet_run = (ph == 3);
      for (int n = 0; n < PollsPerPhase; n++) begin
        // Hold off the receiver so the block backs up into its input
        if (ph == 4 && n == 20) hold_asks++;
        // Pause the sender until everything in flight has come out
        if (ph == 4 && n == 90) drain_results();
        send_poll(random_poll(), 1'b0, '0);
      end
    end

    drain_results();
    quiet_run = 1'b0;
    // Catch any stray result after the last expected one
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
